FILE: hw/rtl/two_level_page_table_unit_assert.svh
// Assertion macros for the two-level page table unit checker.
// Needs signals i_clk and i_rst_n in the scope of use.
`ifndef TWO_LEVEL_PAGE_TABLE_UNIT_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_UNIT_ASSERT_SVH

// cons must hold in the cycle after ante, outside reset
`define PTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ptu check failed");

// cons must hold in the same cycle as ante, outside reset
`define PTU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ptu check failed");

// cons must hold in the cycle after ante, reset included
`define PTU_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error("ptu check failed");

`endif

FILE: hw/rtl/ptu_pkg.sv
// Shared constants, types and codes of the two-level page table unit.
// No dependencies.
package ptu_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_POOL    = 16;

    localparam int FUNC_W   = 2;
    localparam int VPN_W    = 20;
    localparam int IDX_W    = 10;
    localparam int FRAME_W  = 20;
    localparam int FLAGS_W  = 11;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 32;

    localparam int DIR_AW     = $clog2(DIR_ENTRIES);
    localparam int TBL_AW     = $clog2(TABLE_ENTRIES);
    localparam int POOL_W     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int USED_W     = $clog2(TABLE_POOL + 1);
    localparam int DIR_W      = 1 + POOL_W;
    localparam int TBL_ADDR_W = POOL_W + TBL_AW;
    localparam int TBL_DEPTH  = 1 << TBL_ADDR_W;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_MAP    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_UNMAP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IN_USE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd3;

    // result selection from controller to datapath
    typedef logic [2:0] t_res;
    localparam t_res RES_OK_NONE    = 3'd0;
    localparam t_res RES_OK_FRAME   = 3'd1;
    localparam t_res RES_IN_USE     = 3'd2;
    localparam t_res RES_NO_TABLE   = 3'd3;
    localparam t_res RES_NOT_MAPPED = 3'd4;

    typedef struct packed {
        logic capture;  // latch input, read directory
        logic clr_wr;   // directory clear write after reset
        logic alloc;    // attach next pool table to directory entry
        logic swp_wr;   // table clear sweep write
        logic tbl_rd;   // read table entry
        logic tbl_wr;   // write back table entry
        logic out_ld;   // load output register
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic range_ok;
        logic dir_present;
        logic pool_free;
        logic tbl_present;
        logic clr_last;
        logic swp_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/ptu_ctrl.sv
// Sequencer of the page table unit: clear pass, directory check, table sweep, table check.
// Depends on ptu_pkg.
module ptu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ptu_pkg::t_sts i_sts,
    output ptu_pkg::t_cmd o_cmd
);
    import ptu_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIR  = 3'd2;
    localparam logic [2:0] S_SWP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_TBL  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DIR;
                end
            end
            S_DIR: begin
                if (i_sts.func == FN_MAP && i_sts.range_ok && !i_sts.dir_present
                    && i_sts.pool_free) begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_SWP;
                end else if (i_sts.func != FN_NONE && i_sts.range_ok
                             && i_sts.dir_present) begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state      = S_TBL;
                end else if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.res    = (i_sts.func == FN_MAP) ? RES_NO_TABLE : RES_NOT_MAPPED;
                    n_state      = S_IDLE;
                end
            end
            S_SWP: begin
                o_cmd.swp_wr = 1'b1;
                if (i_sts.swp_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.res    = RES_OK_NONE;
                    n_state      = S_IDLE;
                end
            end
            S_TBL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                    if (i_sts.func == FN_MAP) begin
                        if (i_sts.tbl_present) begin
                            o_cmd.res = RES_IN_USE;
                        end else begin
                            o_cmd.tbl_wr = 1'b1;
                            o_cmd.res    = RES_OK_NONE;
                        end
                    end else if (!i_sts.tbl_present) begin
                        o_cmd.res = RES_NOT_MAPPED;
                    end else begin
                        o_cmd.tbl_wr = (i_sts.func == FN_UNMAP);
                        o_cmd.res    = RES_OK_FRAME;
                    end
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ptu_dpath.sv
// Datapath of the page table unit: directory and table memories, pool count,
// input latch and output register. Depends on ptu_pkg.
module ptu_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ptu_pkg::FUNC_W-1:0]      i_func,
    input  logic [ptu_pkg::VPN_W-1:0]       i_virtual_page,
    input  logic [ptu_pkg::FRAME_W-1:0]     i_frame_number,
    input  logic [ptu_pkg::FLAGS_W-1:0]     i_entry_flags,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [ptu_pkg::STATUS_W-1:0]    o_status,
    output logic [ptu_pkg::FRAME_W-1:0]     o_result_frame,
    input  ptu_pkg::t_cmd                   i_cmd,
    output ptu_pkg::t_sts                   o_sts
);
    import ptu_pkg::*;

    logic [DIR_W-1:0]   dir_mem [DIR_ENTRIES];
    logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];

    logic [FUNC_W-1:0]   r_func;
    logic [VPN_W-1:0]    r_vpage;
    logic [FRAME_W-1:0]  r_frame_in;
    logic [FLAGS_W-1:0]  r_flags;
    logic [DIR_W-1:0]    r_dir_q;
    logic [ENTRY_W-1:0]  r_tbl_q;
    logic [POOL_W-1:0]   r_tbl_sel;
    logic [USED_W-1:0]   r_used;
    logic [DIR_AW-1:0]   r_clr_cnt;
    logic [TBL_AW-1:0]   r_swp_cnt;
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_status;
    logic [FRAME_W-1:0]  r_rframe;

    logic [IDX_W-1:0]      dir_idx;
    logic [IDX_W-1:0]      tbl_idx;
    logic [TBL_AW-1:0]     ti;
    logic [DIR_AW-1:0]     dir_wr_addr;
    logic [DIR_W-1:0]      dir_wr_data;
    logic [TBL_ADDR_W-1:0] tbl_addr;
    logic [ENTRY_W-1:0]    new_entry;
    logic [ENTRY_W-1:0]    tbl_wr_data;
    logic                  out_free;

    assign dir_idx   = r_vpage[VPN_W-1:IDX_W];
    assign tbl_idx   = r_vpage[IDX_W-1:0];
    assign ti        = r_vpage[TBL_AW-1:0];
    assign new_entry = {r_frame_in, r_flags, 1'b1};
    assign out_free  = !r_o_valid || i_ready;

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_vpage    <= i_virtual_page;
            r_frame_in <= i_frame_number;
            r_flags    <= i_entry_flags;
        end
    end

    // directory: clear pass writes zeros, alloc marks the entry present
    assign dir_wr_addr = i_cmd.clr_wr ? r_clr_cnt : dir_idx[DIR_AW-1:0];
    assign dir_wr_data = i_cmd.clr_wr ? '0 : {1'b1, r_used[POOL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.alloc) begin
            dir_mem[dir_wr_addr] <= dir_wr_data;
        end
        if (i_cmd.capture) begin
            r_dir_q <= dir_mem[i_virtual_page[IDX_W +: DIR_AW]];
        end
    end

    // table memory: sweep clears a fresh table and drops the new entry in
    assign tbl_addr = i_cmd.swp_wr ? {r_tbl_sel, r_swp_cnt} : {r_dir_q[POOL_W-1:0], ti};

    always_comb begin
        if (i_cmd.swp_wr) begin
            tbl_wr_data = (r_swp_cnt == ti) ? new_entry : '0;
        end else if (r_func == FN_MAP) begin
            tbl_wr_data = new_entry;
        end else begin
            tbl_wr_data = {r_tbl_q[ENTRY_W-1:1], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.swp_wr || i_cmd.tbl_wr) begin
            tbl_mem[tbl_addr] <= tbl_wr_data;
        end
        if (i_cmd.tbl_rd) begin
            r_tbl_q <= tbl_mem[tbl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_tbl_sel <= r_used[POOL_W-1:0];
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_clr_cnt <= '0;
            r_swp_cnt <= '0;
        end else begin
            if (i_cmd.alloc) begin
                r_used    <= r_used + 1'b1;
                r_swp_cnt <= '0;
            end else if (i_cmd.swp_wr) begin
                r_swp_cnt <= r_swp_cnt + 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_rframe <= (i_cmd.res == RES_OK_FRAME) ? r_tbl_q[ENTRY_W-1 -: FRAME_W] : '0;
            case (i_cmd.res)
                RES_OK_NONE:  r_status <= ST_OK;
                RES_OK_FRAME: r_status <= ST_OK;
                RES_IN_USE:   r_status <= ST_IN_USE;
                RES_NO_TABLE: r_status <= ST_NO_TABLE;
                default:      r_status <= ST_NOT_MAPPED;
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_status;
    assign o_result_frame = r_rframe;

    always_comb begin
        o_sts             = '0;
        o_sts.func        = r_func;
        o_sts.range_ok    = ({1'b0, dir_idx} < (IDX_W + 1)'(DIR_ENTRIES))
                            && ({1'b0, tbl_idx} < (IDX_W + 1)'(TABLE_ENTRIES));
        o_sts.dir_present = r_dir_q[POOL_W];
        o_sts.pool_free   = r_used < USED_W'(TABLE_POOL);
        o_sts.tbl_present = r_tbl_q[0];
        o_sts.clr_last    = r_clr_cnt == DIR_AW'(DIR_ENTRIES - 1);
        o_sts.swp_last    = r_swp_cnt == TBL_AW'(TABLE_ENTRIES - 1);
        o_sts.out_free    = out_free;
    end

endmodule

FILE: hw/rtl/two_level_page_table_unit.sv
// Two-level page table unit: one directory of DIR_ENTRIES entries over a pool
// of TABLE_POOL second-level tables of TABLE_ENTRIES 32-bit entries each.
// Operations map, unmap and lookup address the tables by virtual page number
// (upper 10 bits directory index, lower 10 bits table index); every input
// transfer gives exactly one result transfer carrying status and frame.
// Timing: after reset the directory is swept clear, one entry per cycle, with
// o_ready low. An item then goes from its input transfer through the directory
// read, a check of the directory entry with the table read, and a check of the
// table entry with its write-back and the loading of the result; without a
// directory entry its result is loaded at the directory check. A map that has
// to attach a fresh table instead clears it through the single write port of
// the table memory, one entry per cycle, before its result is loaded.
// One item is in flight at a time; a finished result sits in the output
// register, so the next item is taken while that result still waits.
// Depends on ptu_pkg, ptu_ctrl and ptu_dpath.
module two_level_page_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ptu_pkg::FUNC_W-1:0]      i_func,
    input  logic [ptu_pkg::VPN_W-1:0]       i_virtual_page,
    input  logic [ptu_pkg::FRAME_W-1:0]     i_frame_number,
    input  logic [ptu_pkg::FLAGS_W-1:0]     i_entry_flags,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ptu_pkg::STATUS_W-1:0]    o_status,
    output logic [ptu_pkg::FRAME_W-1:0]     o_result_frame
);
    import ptu_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    ptu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // memories, pool counter and output register
    ptu_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_virtual_page (i_virtual_page),
        .i_frame_number (i_frame_number),
        .i_entry_flags  (i_entry_flags),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_frame (o_result_frame),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

FILE: hw/rtl/ptu_chk.sv
// Port-level checker for the two-level page table unit, bound to the top.
// Depends on ptu_pkg and two_level_page_table_unit_assert.svh.
`include "two_level_page_table_unit_assert.svh"

module ptu_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [ptu_pkg::FUNC_W-1:0]      i_func,
    input logic [ptu_pkg::VPN_W-1:0]       i_virtual_page,
    input logic [ptu_pkg::FRAME_W-1:0]     i_frame_number,
    input logic [ptu_pkg::FLAGS_W-1:0]     i_entry_flags,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [ptu_pkg::STATUS_W-1:0]    o_status,
    input logic [ptu_pkg::FRAME_W-1:0]     o_result_frame
);
    import ptu_pkg::*;

    // a stalled result stays offered
    `PTU_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)

    // frame only travels with an ok status
    `PTU_ASSERT_SAME(a_frame_zero, o_valid && o_status != ST_OK, o_result_frame == '0)

    // one item at a time: no input transfer right after another
    `PTU_ASSERT_NEXT(a_one_inflight, i_valid && o_ready, !o_ready)

    // reset leaves both channels quiet while the directory is cleared
    `PTU_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n, !o_valid && !o_ready)

endmodule

bind two_level_page_table_unit ptu_chk u_ptu_chk (.*);
